FILE: rtl/awdc_pkg.sv
// awdc_pkg: shared types and constants for the anagram window distinct counter
// used by rtl/anagram_window_distinct_counter.sv
`timescale 1ns / 1ps

package awdc_pkg;

    localparam int unsigned MaxPatternLen = 256;
    localparam int unsigned TableDepth    = 1024;
    localparam int unsigned Letters       = 26;
    localparam logic [7:0]  HashBase      = 8'd131;

    // action codes of a request
    typedef enum logic [1:0] {
        ACT_PATTERN = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_FINISH  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT,
        S_GONE,
        S_DEC,
        S_RDI,
        S_INC,
        S_SCAN,
        S_EMIT
    } state_t;

    // result flags waiting for the output register
    typedef struct packed {
        logic match;
        logic fresh;
        logic full;
        logic lerr;
    } flags_t;

endpackage

FILE: rtl/anagram_window_distinct_counter.sv
// anagram_window_distinct_counter: top level, sequencer around three memories
// depends on rtl/awdc_pkg.sv
`timescale 1ns / 1ps

// Usage: one input channel (in_valid, in_stall, action, letter) and one
// output channel (out_valid, out_stall and the result fields). A request is
// taken when in_valid is high and in_stall low; each request gives exactly
// one result. Pattern letters come first, then text letters, then a finish
// request that reports the distinct matching window count and clears all.
// Finish, dropped or ignored requests go straight to the output stage; a
// pattern letter first reads the letter count memory; a text letter passes
// through the delay line and letter count memory reads and, for a matching
// window, a scan of the seen-table memory in fill order. One request is in
// work at a time.
// Reset clears all control state at once; the seen-table needs no valid
// bits since it fills in order and the fill count marks the valid entries.
// If the receiver stalls, the result stays in the output register and the
// block finishes its next request only up to the point of loading it.
module anagram_window_distinct_counter #(
    parameter int unsigned MAX_PATTERN_LEN = awdc_pkg::MaxPatternLen,
    parameter int unsigned TABLE_DEPTH     = awdc_pkg::TableDepth,
    localparam int unsigned TW = $clog2(TABLE_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    action,
    input  logic [4:0]    letter,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          window_match,
    output logic          newly_seen,
    output logic [TW:0]   distinct_count,
    output logic          table_full,
    output logic          length_error
);

    localparam int unsigned CW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int unsigned AW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int unsigned LW = 5;
    localparam int unsigned HW = 2 * CW;

    awdc_pkg::state_t state_reg, state_next;
    awdc_pkg::flags_t res_reg, res_next;

    logic [LW-1:0]   letter_reg, letter_next;
    logic [LW-1:0]   gone_reg, gone_next;
    logic [63:0]     hash_reg, hash_next;
    logic [63:0]     bp_reg, bp_next;
    logic [CW-1:0]   plen_reg, plen_next;
    logic [CW-1:0]   seen_reg, seen_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [4:0]      mism_reg, mism_next;
    logic [4:0]      pdist_reg, pdist_next;
    logic [TW:0]     total_reg, total_next;
    logic [TW:0]     k_reg, k_next;
    logic            cmpv_reg, cmpv_next;
    logic            fin_reg, fin_next;
    logic [25:0]     pvalid_reg, pvalid_next;
    logic [25:0]     wvalid_reg, wvalid_next;

    logic            out_valid_reg, out_valid_next;
    awdc_pkg::flags_t out_flags_reg, out_flags_next;
    logic [TW:0]     out_count_reg, out_count_next;

    // memories and their ports
    logic [HW-1:0]   hist_mem [awdc_pkg::Letters];
    logic [HW-1:0]   hist_rd_reg;
    logic [LW-1:0]   hist_addr_reg;
    logic            hist_re, hist_we;
    logic [LW-1:0]   hist_ra, hist_wa;
    logic [HW-1:0]   hist_wd;

    logic [LW-1:0]   dl_mem [MAX_PATTERN_LEN];
    logic [LW-1:0]   dl_rd_reg;
    logic            dl_re, dl_we;

    logic [63:0]     tbl_mem [TABLE_DEPTH];
    logic [63:0]     tbl_rd_reg;
    logic            tbl_re, tbl_we;
    logic [TW-1:0]   tbl_ra;

    // resolved letter counts of the last read entry
    logic [CW-1:0]   pat_cnt, win_cnt, win_dec, win_inc;
    logic [CW:0]     ptr_inc;
    logic [CW-1:0]   seen_inc;
    logic            accept;

    assign pat_cnt  = pvalid_reg[hist_addr_reg] ? hist_rd_reg[HW-1:CW] : '0;
    assign win_cnt  = wvalid_reg[hist_addr_reg] ? hist_rd_reg[CW-1:0] : '0;
    assign win_dec  = win_cnt - 1'b1;
    assign win_inc  = win_cnt + 1'b1;
    assign ptr_inc  = {{(CW + 1 - AW){1'b0}}, ptr_reg} + 1'b1;
    assign seen_inc = seen_reg + 1'b1;

    assign in_stall = (state_reg != awdc_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    // letter count memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re)
        begin
            hist_rd_reg   <= hist_mem[hist_ra];
            hist_addr_reg <= hist_ra;
        end
    end

    // delay line memory
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[ptr_reg] <= letter_reg;
        end
        if (dl_re)
        begin
            dl_rd_reg <= dl_mem[ptr_reg];
        end
    end

    // seen-table memory, filled in order
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[total_reg[TW-1:0]] <= hash_reg;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[tbl_ra];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awdc_pkg::S_IDLE;
            res_reg       <= '0;
            letter_reg    <= '0;
            gone_reg      <= '0;
            hash_reg      <= '0;
            bp_reg        <= 64'd1;
            plen_reg      <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            mism_reg      <= '0;
            pdist_reg     <= '0;
            total_reg     <= '0;
            k_reg         <= '0;
            cmpv_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            pvalid_reg    <= '0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_flags_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            letter_reg    <= letter_next;
            gone_reg      <= gone_next;
            hash_reg      <= hash_next;
            bp_reg        <= bp_next;
            plen_reg      <= plen_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            mism_reg      <= mism_next;
            pdist_reg     <= pdist_next;
            total_reg     <= total_next;
            k_reg         <= k_next;
            cmpv_reg      <= cmpv_next;
            fin_reg       <= fin_next;
            pvalid_reg    <= pvalid_next;
            wvalid_reg    <= wvalid_next;
            out_valid_reg <= out_valid_next;
            out_flags_reg <= out_flags_next;
            out_count_reg <= out_count_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        letter_next    = letter_reg;
        gone_next      = gone_reg;
        hash_next      = hash_reg;
        bp_next        = bp_reg;
        plen_next      = plen_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        mism_next      = mism_reg;
        pdist_next     = pdist_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        cmpv_next      = cmpv_reg;
        fin_next       = fin_reg;
        pvalid_next    = pvalid_reg;
        wvalid_next    = wvalid_reg;
        out_valid_next = out_valid_reg;
        out_flags_next = out_flags_reg;
        out_count_next = out_count_reg;
        hist_re        = 1'b0;
        hist_ra        = letter_reg;
        hist_we        = 1'b0;
        hist_wa        = hist_addr_reg;
        hist_wd        = hist_rd_reg;
        dl_re          = 1'b0;
        dl_we          = 1'b0;
        tbl_re         = 1'b0;
        tbl_we         = 1'b0;
        tbl_ra         = k_reg[TW-1:0];

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            awdc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    letter_next = letter;
                    res_next    = '0;
                    fin_next    = 1'b0;
                    state_next  = awdc_pkg::S_EMIT;
                    if (action == awdc_pkg::ACT_FINISH)
                    begin
                        fin_next = 1'b1;
                    end
                    else if (action == awdc_pkg::ACT_PATTERN && letter < LW'(awdc_pkg::Letters))
                    begin
                        if (plen_reg >= CW'(MAX_PATTERN_LEN))
                        begin
                            res_next.lerr = 1'b1;
                        end
                        else
                        begin
                            hist_re    = 1'b1;
                            hist_ra    = letter;
                            state_next = awdc_pkg::S_PAT;
                        end
                    end
                    else if (action == awdc_pkg::ACT_TEXT && letter < LW'(awdc_pkg::Letters)
                             && plen_reg != '0)
                    begin
                        dl_re      = 1'b1;
                        state_next = awdc_pkg::S_GONE;
                    end
                end
            end

            awdc_pkg::S_PAT:
            begin
                // bump pattern count and restart the text window
                hist_we      = 1'b1;
                hist_wd      = {pat_cnt + 1'b1, {CW{1'b0}}};
                wvalid_next  = '0;
                wvalid_next[hist_addr_reg] = 1'b1;
                pvalid_next[hist_addr_reg] = 1'b1;
                pdist_next   = pdist_reg + ((pat_cnt == '0) ? 5'd1 : 5'd0);
                mism_next    = pdist_next;
                plen_next    = plen_reg + 1'b1;
                bp_next      = bp_reg * 64'(awdc_pkg::HashBase);
                seen_next    = '0;
                ptr_next     = '0;
                hash_next    = '0;
                state_next   = awdc_pkg::S_EMIT;
            end

            awdc_pkg::S_GONE:
            begin
                hist_re = 1'b1;
                if (seen_reg >= plen_reg)
                begin
                    gone_next  = dl_rd_reg;
                    hist_ra    = dl_rd_reg;
                    state_next = awdc_pkg::S_DEC;
                end
                else
                begin
                    seen_next  = seen_inc;
                    hash_next  = hash_reg * 64'(awdc_pkg::HashBase) + 64'(letter_reg);
                    state_next = awdc_pkg::S_INC;
                end
            end

            awdc_pkg::S_DEC:
            begin
                // drop the oldest letter from the window
                hist_we  = 1'b1;
                hist_wd  = {hist_rd_reg[HW-1:CW], win_dec};
                wvalid_next[hist_addr_reg] = 1'b1;
                if (win_cnt == pat_cnt)
                begin
                    mism_next = mism_reg + 5'd1;
                end
                else if (win_dec == pat_cnt)
                begin
                    mism_next = mism_reg - 5'd1;
                end
                hash_next  = hash_reg * 64'(awdc_pkg::HashBase) + 64'(letter_reg)
                             - 64'(gone_reg) * bp_reg;
                state_next = awdc_pkg::S_RDI;
            end

            awdc_pkg::S_RDI:
            begin
                hist_re    = 1'b1;
                state_next = awdc_pkg::S_INC;
            end

            awdc_pkg::S_INC:
            begin
                // add the new letter and advance the delay line
                hist_we  = 1'b1;
                hist_wd  = {hist_rd_reg[HW-1:CW], win_inc};
                wvalid_next[hist_addr_reg] = 1'b1;
                if (win_cnt == pat_cnt)
                begin
                    mism_next = mism_reg + 5'd1;
                end
                else if (win_inc == pat_cnt)
                begin
                    mism_next = mism_reg - 5'd1;
                end
                dl_we    = 1'b1;
                ptr_next = (ptr_inc >= {1'b0, plen_reg}) ? '0 : ptr_inc[AW-1:0];
                if (seen_reg >= plen_reg && mism_next == '0)
                begin
                    res_next.match = 1'b1;
                    k_next         = '0;
                    cmpv_next      = 1'b0;
                    state_next     = awdc_pkg::S_SCAN;
                end
                else
                begin
                    state_next = awdc_pkg::S_EMIT;
                end
            end

            awdc_pkg::S_SCAN:
            begin
                // walk stored hashes in fill order, one read per cycle
                if (cmpv_reg && tbl_rd_reg == hash_reg)
                begin
                    state_next = awdc_pkg::S_EMIT;
                end
                else if (k_reg < total_reg)
                begin
                    tbl_re    = 1'b1;
                    k_next    = k_reg + 1'b1;
                    cmpv_next = 1'b1;
                end
                else if (total_reg < (TW+1)'(TABLE_DEPTH))
                begin
                    tbl_we         = 1'b1;
                    total_next     = total_reg + 1'b1;
                    res_next.fresh = 1'b1;
                    state_next     = awdc_pkg::S_EMIT;
                end
                else
                begin
                    res_next.full = 1'b1;
                    state_next    = awdc_pkg::S_EMIT;
                end
            end

            awdc_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_flags_next = res_reg;
                    out_count_next = total_reg;
                    if (fin_reg)
                    begin
                        // old count goes out, then back to reset values
                        total_next  = '0;
                        pvalid_next = '0;
                        wvalid_next = '0;
                        plen_next   = '0;
                        bp_next     = 64'd1;
                        seen_next   = '0;
                        ptr_next    = '0;
                        hash_next   = '0;
                        mism_next   = '0;
                        pdist_next  = '0;
                    end
                    state_next = awdc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = awdc_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign window_match   = out_flags_reg.match;
    assign newly_seen     = out_flags_reg.fresh;
    assign table_full     = out_flags_reg.full;
    assign length_error   = out_flags_reg.lerr;
    assign distinct_count = out_count_reg;

endmodule

FILE: sim/anagram_window_distinct_counter_tb.sv
// anagram_window_distinct_counter_tb: self-checking bench for the anagram window counter
// depends on rtl/awdc_pkg.sv and rtl/anagram_window_distinct_counter.sv
`timescale 1ns / 1ps

module anagram_window_distinct_counter_tb;

    localparam int unsigned PatMax   = awdc_pkg::MaxPatternLen;
    localparam int unsigned SeenMax  = awdc_pkg::TableDepth;
    localparam int unsigned Watchdog = 20000;

    // one result as seen on the output port
    typedef struct packed {
        logic        match;
        logic        fresh;
        logic [10:0] count;
        logic        full;
        logic        lerr;
    } result_t;

    // one directed row: request plus optional typed-in answer
    typedef struct {
        awdc_pkg::action_t act;
        logic [4:0] let_code;
        bit         typed;
        result_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [4:0]  letter;
    logic        out_valid;
    logic        out_stall;
    logic        window_match;
    logic        newly_seen;
    logic [10:0] distinct_count;
    logic        table_full;
    logic        length_error;

    anagram_window_distinct_counter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .letter         (letter),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_match   (window_match),
        .newly_seen     (newly_seen),
        .distinct_count (distinct_count),
        .table_full     (table_full),
        .length_error   (length_error)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state
    logic [8:0]  pat_hist [awdc_pkg::Letters];
    logic [8:0]  win_hist [awdc_pkg::Letters];
    logic [8:0]  pat_len;
    logic [8:0]  text_cnt;
    logic [4:0]  recent [PatMax];
    logic [8:0]  ring_ptr;
    logic [63:0] roll_hash;
    logic [63:0] top_power;
    logic [63:0] seen_keys [$];

    result_t     expected_results [$];
    int          mismatches;
    int          idle_cycles = 0;
    bit          calm;
    bit          timed_out;

    // clear the current text window
    function automatic void clear_window();
        for (int j = 0; j < awdc_pkg::Letters; j++)
        begin
            win_hist[j] = '0;
        end
        text_cnt  = '0;
        ring_ptr  = '0;
        roll_hash = '0;
    endfunction

    function automatic void clear_all();
        for (int j = 0; j < awdc_pkg::Letters; j++)
        begin
            pat_hist[j] = '0;
        end
        pat_len   = '0;
        top_power = 64'd1;
        seen_keys.delete();
        clear_window();
    endfunction

    // work out the result of one request and advance the predictor
    function automatic result_t predict_anagram(logic [1:0] act, logic [4:0] code);
        result_t r;
        bit      same;
        bit      hit;
        int      p;
        logic [4:0] gone;
        r = '0;
        if (act == awdc_pkg::ACT_FINISH)
        begin
            r.count = 11'(seen_keys.size());
            clear_all();
            return r;
        end
        if (act == awdc_pkg::ACT_PATTERN && code < awdc_pkg::Letters)
        begin
            if (pat_len >= PatMax)
            begin
                r.lerr = 1'b1;
            end
            else
            begin
                pat_hist[code] += 1;
                pat_len   += 1;
                top_power *= 64'd131;
                clear_window();
            end
        end
        else if (act == awdc_pkg::ACT_TEXT && code < awdc_pkg::Letters && pat_len != 0)
        begin
            p = ring_ptr;
            if (text_cnt >= pat_len)
            begin
                gone = recent[p];
                win_hist[gone] -= 1;
                roll_hash = roll_hash * 64'd131 + 64'(code) - 64'(gone) * top_power;
            end
            else
            begin
                text_cnt += 1;
                roll_hash = roll_hash * 64'd131 + 64'(code);
            end
            recent[p] = code;
            p++;
            ring_ptr = (p >= pat_len) ? 9'd0 : 9'(p);
            win_hist[code] += 1;
            same = 1'b1;
            for (int j = 0; j < awdc_pkg::Letters; j++)
            begin
                if (win_hist[j] != pat_hist[j])
                begin
                    same = 1'b0;
                end
            end
            if (text_cnt >= pat_len && same)
            begin
                r.match = 1'b1;
                hit = 1'b0;
                foreach (seen_keys[k])
                begin
                    if (seen_keys[k] == roll_hash)
                    begin
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    if (seen_keys.size() < SeenMax)
                    begin
                        seen_keys.push_back(roll_hash);
                        r.fresh = 1'b1;
                    end
                    else
                    begin
                        r.full = 1'b1;
                    end
                end
            end
        end
        r.count = 11'(seen_keys.size());
        return r;
    endfunction

    // drive one request, holding it until accepted
    task automatic send_request(logic [1:0] act, logic [4:0] code, bit typed, result_t want);
        result_t got;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        action   <= act;
        letter   <= code;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        got = predict_anagram(act, code);
        if (typed && got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("directed row disagrees with predictor: typed %h predicted %h",
                    want, got);
            end
        end
        expected_results.push_back(got);
        @(negedge clk);
    endtask

    // receiver stall bursts
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {window_match, newly_seen, distinct_count, table_full, length_error};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", got);
                end
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected m%0d f%0d c%0d full%0d le%0d, got m%0d f%0d c%0d full%0d le%0d",
                            exp_r.match, exp_r.fresh, exp_r.count, exp_r.full, exp_r.lerr,
                            got.match, got.fresh, got.count, got.full, got.lerr);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > Watchdog)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // random words drawn from a small alphabet so anagrams appear often
    task automatic random_job(int plen, int tlen, int alpha);
        result_t none;
        none = '0;
        for (int i = 0; i < plen; i++)
        begin
            send_request(awdc_pkg::ACT_PATTERN, 5'($urandom_range(0, alpha - 1)), 0, none);
        end
        for (int i = 0; i < tlen; i++)
        begin
            send_request(awdc_pkg::ACT_TEXT, 5'($urandom_range(0, alpha - 1)), 0, none);
        end
        send_request(awdc_pkg::ACT_FINISH, 5'($urandom_range(0, 31)), 0, none);
    endtask

    row_t rows [$];
    result_t none;

    initial
    begin
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        action      <= awdc_pkg::ACT_NONE;
        letter      <= '0;
        mismatches  = 0;
        calm        = 1'b0;
        none        = '0;
        clear_all();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed table: text with empty pattern, ignored codes, extremes, finish
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  1, result_t'('0)});
        rows.push_back('{awdc_pkg::ACT_NONE,    5'd31, 1, result_t'('0)});
        rows.push_back('{awdc_pkg::ACT_PATTERN, 5'd26, 1, result_t'('0)});
        rows.push_back('{awdc_pkg::ACT_PATTERN, 5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_PATTERN, 5'd25, 0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd25, 0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd25, 0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd31, 0, none});
        // pattern letter after text restarts the window
        rows.push_back('{awdc_pkg::ACT_PATTERN, 5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd25, 0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_TEXT,    5'd0,  0, none});
        rows.push_back('{awdc_pkg::ACT_FINISH,  5'd17, 0, none});
        rows.push_back('{awdc_pkg::ACT_FINISH,  5'd0,  1, result_t'('0)});
        foreach (rows[i])
        begin
            send_request(rows[i].act, rows[i].let_code, rows[i].typed, rows[i].want);
        end

        // overlong pattern: fill to the maximum, then one letter is dropped
        for (int i = 0; i < PatMax; i++)
        begin
            send_request(awdc_pkg::ACT_PATTERN, 5'(i % 26), 0, none);
        end
        send_request(awdc_pkg::ACT_PATTERN, 5'd3, 1,
            result_t'({1'b0, 1'b0, 11'd0, 1'b0, 1'b1}));
        send_request(awdc_pkg::ACT_TEXT, 5'd3, 0, none);
        send_request(awdc_pkg::ACT_FINISH, 5'd0, 0, none);

        // sender holds off until all results are back
        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge clk);

        // random jobs, mostly short patterns over small alphabets
        for (int j = 0; j < 16; j++)
        begin
            random_job($urandom_range(1, 4), $urandom_range(5, 30), $urandom_range(1, 4));
        end
        // noise: any action and letter code
        for (int i = 0; i < 40; i++)
        begin
            send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 0, none);
        end
        send_request(awdc_pkg::ACT_FINISH, 5'd0, 0, none);

        // final stretch with no idling: length-3 pattern over three letters,
        // so many windows match and the seen-table is scanned often
        calm = 1'b1;
        send_request(awdc_pkg::ACT_PATTERN, 5'd0, 0, none);
        send_request(awdc_pkg::ACT_PATTERN, 5'd1, 0, none);
        send_request(awdc_pkg::ACT_PATTERN, 5'd2, 0, none);
        for (int i = 0; i < 40; i++)
        begin
            send_request(awdc_pkg::ACT_TEXT, 5'($urandom_range(0, 2)), 0, none);
        end
        send_request(awdc_pkg::ACT_FINISH, 5'd0, 0, none);
        in_valid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (2 * SeenMax + 20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
